### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, sampled on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define WBIP_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wbip assertion failed");

// Next-cycle implication
`define WBIP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wbip assertion failed");

`endif

### design/wbip_pkg.sv
// ----------------------------------------------------------------------------
// wbip_pkg
// Types and fixed constants of the waveform bank island parser.
// ----------------------------------------------------------------------------
package wbip_pkg;

   localparam int DATA_W = 32;
   localparam int LEN_W  = 21;
   localparam int DBC_W  = 6;
   localparam int PERS_W = 4;
   localparam int CODE_W = 3;
   localparam int CSR_W  = 6;

   localparam logic [DATA_W-1:0] TIME_MASK        = 32'hEFFF_FFFF;
   localparam logic [DATA_W-1:0] BIG_REQUEST      = 32'h0010_0000;
   localparam logic [PERS_W-1:0] GOOD_PERSONALITY = 4'd2;

   // Register indexes
   localparam logic REG_BLOCKS_DBC  = 1'b0;
   localparam logic REG_PERSONALITY = 1'b1;

   // Bank status codes
   localparam logic [CODE_W-1:0] STS_OK          = 3'd0;
   localparam logic [CODE_W-1:0] STS_PERSONALITY = 3'd1;
   localparam logic [CODE_W-1:0] STS_SHORT       = 3'd2;
   localparam logic [CODE_W-1:0] STS_ZERO_REQ    = 3'd3;
   localparam logic [CODE_W-1:0] STS_BIG_REQ     = 3'd4;
   localparam logic [CODE_W-1:0] STS_MISMATCH    = 3'd5;
   localparam logic [CODE_W-1:0] STS_SIZE        = 3'd6;
   localparam logic [CODE_W-1:0] STS_TIME        = 3'd7;

   // Result kinds
   localparam logic KIND_SAMPLES = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   // Remainder unit status
   typedef struct packed {
      logic busy;
      logic rem_zero;
   } rem_status_type;

endpackage

### design/wbip_buf_mem.sv
// ----------------------------------------------------------------------------
// wbip_buf_mem
// Block sample buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wbip_buf_mem
   import wbip_pkg::*;
#(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/wbip_rem_unit.sv
// ----------------------------------------------------------------------------
// wbip_rem_unit
// Bit-serial remainder of bank length minus 4 by block size, one bit a cycle.
// ----------------------------------------------------------------------------
module wbip_rem_unit
   import wbip_pkg::*;
#(
   parameter int BLEN_W = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [LEN_W-1:0]  dividend,
   input  logic [BLEN_W-1:0] divisor,
   output rem_status_type    status
);

   localparam int CNT_W = $clog2(LEN_W + 1);

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [LEN_W-1:0]  dvd_ff, dvd_in;
   logic [BLEN_W-1:0] dsr_ff, dsr_in;
   logic [BLEN_W-1:0] rem_ff, rem_in;
   logic [BLEN_W:0]   trial;

   // One restoring step per cycle
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[LEN_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(LEN_W);
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            trial = trial - {1'b0, dsr_ff};
         end
         rem_in = trial[BLEN_W-1:0];
         dvd_in = {dvd_ff[LEN_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign status.busy     = busy_ff;
   assign status.rem_zero = (rem_ff == '0);

endmodule

### design/waveform_bank_island_parser.sv
// ----------------------------------------------------------------------------
// waveform_bank_island_parser
// Parses a digitizer bank word by word, buffers each block, groups blocks
// into islands by time and emits samples four per word plus a bank status.
// ----------------------------------------------------------------------------
//  channel | ports                              | direction
//  --------+------------------------------------+----------
//  req     | req_valid / req_stall, bank words  | in
//  rsp     | rsp_valid / rsp_stall, results     | out
//  csr     | csr_wr_en, csr_index, csr_data     | in
//
// The first word of a bank of good personality and length three or more
// starts a serial length remainder; words stall until it is done. A block's
// time word drains 2*dbc buffered words via the registered buffer read, at
// up to one result per cycle while rsp_stall allows; input stalls meanwhile.
// Status results load in the cycle their word is taken. Synchronous reset;
// the buffer needs no clearing pass. rsp_stall holds the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module waveform_bank_island_parser
   import wbip_pkg::*;
#(
   parameter int MAX_DBC = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   // configuration
   input  logic                     csr_wr_en,
   input  logic                     csr_index,
   input  logic [CSR_W-1:0]         csr_data,
   // input words
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [DATA_W-1:0]        req_data_word,
   input  logic                     req_first_word,
   input  logic [LEN_W-1:0]         req_bank_length,
   // results
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_sample_0,
   output logic [7:0]               rsp_sample_1,
   output logic [7:0]               rsp_sample_2,
   output logic [7:0]               rsp_sample_3,
   output logic                     rsp_new_island,
   output logic signed [DATA_W-1:0] rsp_island_time,
   output logic                     rsp_result_kind,
   output logic [CODE_W-1:0]        rsp_status_code,
   output logic                     rsp_last_of_run
);

   localparam int DEPTH   = 2 * MAX_DBC;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int HDBC_W  = $clog2(MAX_DBC + 1);
   localparam int BLEN_W  = $clog2(2 * MAX_DBC + 3);
   localparam int NW_W    = $clog2(2 * MAX_DBC + 1);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   // Configuration registers
   logic [DBC_W-1:0]  dbc_cfg_ff;
   logic [PERS_W-1:0] pers_cfg_ff;

   // Bank and island state
   logic              state_ff, state_in;
   logic              closed_ff, closed_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [HDBC_W-1:0] dbc_ff, dbc_in;
   logic [DATA_W-1:0] reqcnt_ff, reqcnt_in;
   logic              match_ff, match_in;
   logic [BLEN_W-1:0] blk_ff, blk_in;
   logic [DATA_W-1:0] itime_ff, itime_in;
   logic [DATA_W-1:0] iend_ff, iend_in;
   logic              iopen_ff, iopen_in;
   logic              isnew_ff, isnew_in;

   // Drain sequencer
   logic [NW_W-1:0]   nw_ff, nw_in;
   logic [NW_W-1:0]   iss_ff, iss_in;
   logic              qv_ff, qv_in;
   logic              qfirst_ff, qfirst_in;
   logic              qlast_ff, qlast_in;

   // Output register
   logic              ovalid_ff, ovalid_in;
   logic [DATA_W-1:0] oword_ff, oword_in;
   logic              onew_ff, onew_in;
   logic [DATA_W-1:0] otime_ff, otime_in;
   logic              okind_ff, okind_in;
   logic [CODE_W-1:0] ocode_ff, ocode_in;
   logic              olast_ff, olast_in;

   // Datapath wires
   logic              req_acc;
   logic              out_free;
   logic              drain_issue;
   logic              drain_load;
   logic [HDBC_W-1:0] dbc_clamp;
   logic [BLEN_W-1:0] blen;
   logic [NW_W-1:0]   nwords;
   logic [DATA_W-1:0] samp_inc;
   logic [DATA_W-1:0] tword;
   logic              buf_wr_en;
   logic [DATA_W-1:0] buf_rd_data;
   logic              rem_start;
   rem_status_type    rem_st;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dbc_cfg_ff  <= DBC_W'(1);
         pers_cfg_ff <= GOOD_PERSONALITY;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_BLOCKS_DBC:  dbc_cfg_ff  <= csr_data;
            REG_PERSONALITY: pers_cfg_ff <= csr_data[PERS_W-1:0];
            default:         dbc_cfg_ff  <= dbc_cfg_ff;
         endcase
      end
   end

   // Block geometry
   assign dbc_clamp = (dbc_cfg_ff > DBC_W'(MAX_DBC)) ? HDBC_W'(MAX_DBC)
                                                      : HDBC_W'(dbc_cfg_ff);
   assign blen      = BLEN_W'({dbc_ff, 1'b0}) + BLEN_W'(2);
   assign nwords    = NW_W'({dbc_ff, 1'b0});
   assign samp_inc  = DATA_W'({dbc_ff, 3'b000});
   assign tword     = req_data_word & TIME_MASK;

   // Handshake
   assign out_free    = !ovalid_ff || !rsp_stall;
   assign req_stall   = (state_ff == ST_DRAIN) || rem_st.busy || !out_free;
   assign req_acc     = req_valid && !req_stall;
   assign drain_load  = (state_ff == ST_DRAIN) && qv_ff && out_free;
   assign drain_issue = (state_ff == ST_DRAIN) && (iss_ff != nw_ff) &&
                        (!qv_ff || drain_load);

   // Word processing and drain control
   always_comb begin
      logic             live;
      logic [LEN_W-1:0] pos_eff;
      logic             st_load;
      logic [CODE_W-1:0] st_code;
      logic             st_zero_time;
      logic             later;
      logic             earlier;

      state_in  = state_ff;
      closed_in = closed_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      dbc_in    = dbc_ff;
      reqcnt_in = reqcnt_ff;
      match_in  = match_ff;
      blk_in    = blk_ff;
      itime_in  = itime_ff;
      iend_in   = iend_ff;
      iopen_in  = iopen_ff;
      isnew_in  = isnew_ff;
      nw_in     = nw_ff;
      iss_in    = iss_ff;
      qv_in     = qv_ff;
      qfirst_in = qfirst_ff;
      qlast_in  = qlast_ff;
      ovalid_in = out_free ? 1'b0 : ovalid_ff;
      oword_in  = oword_ff;
      onew_in   = onew_ff;
      otime_in  = otime_ff;
      okind_in  = okind_ff;
      ocode_in  = ocode_ff;
      olast_in  = olast_ff;
      buf_wr_en = 1'b0;
      rem_start = 1'b0;
      st_load   = 1'b0;
      st_code   = STS_OK;
      st_zero_time = 1'b0;
      live      = 1'b0;
      pos_eff   = pos_ff;
      later     = !iopen_ff || ($signed(iend_ff) < $signed(tword));
      earlier   = $signed(tword) < $signed(iend_ff);

      if (req_acc) begin
         // First word opens a bank
         if (req_first_word) begin
            pos_eff      = '0;
            pos_in       = '0;
            blk_in       = '0;
            reqcnt_in    = '0;
            match_in     = 1'b1;
            itime_in     = '0;
            iend_in      = '0;
            iopen_in     = 1'b0;
            closed_in    = 1'b0;
            len_in       = req_bank_length;
            dbc_in       = dbc_clamp;
            st_zero_time = 1'b1;
            if (pers_cfg_ff != GOOD_PERSONALITY) begin
               st_load = 1'b1;
               st_code = STS_PERSONALITY;
            end else if (req_bank_length < LEN_W'(3)) begin
               st_load = 1'b1;
               st_code = STS_SHORT;
            end else begin
               live      = 1'b1;
               rem_start = 1'b1;
            end
         end else begin
            live = !closed_ff && (pos_ff < len_ff);
         end

         if (live) begin
            pos_in = pos_eff + LEN_W'(1);
            if (pos_eff == LEN_W'(0)) begin
               reqcnt_in = req_data_word;
            end else if (pos_eff == LEN_W'(1)) begin
               match_in = (req_data_word == reqcnt_ff);
            end else if (pos_eff == LEN_W'(2)) begin
               // Header checks
               if (reqcnt_ff == '0) begin
                  st_load = 1'b1;
                  st_code = STS_ZERO_REQ;
               end else if (!reqcnt_ff[DATA_W-1] && (reqcnt_ff >= BIG_REQUEST)) begin
                  st_load = 1'b1;
                  st_code = STS_BIG_REQ;
               end else if (!match_ff || (req_data_word != '0)) begin
                  st_load = 1'b1;
                  st_code = STS_MISMATCH;
               end else if ((len_ff < LEN_W'(4)) || !rem_st.rem_zero) begin
                  st_load = 1'b1;
                  st_code = STS_SIZE;
               end
            end else if (pos_eff == len_ff - LEN_W'(1)) begin
               // Spare word closes a good bank
               st_load = 1'b1;
               st_code = STS_OK;
            end else begin
               // Block word
               buf_wr_en = blk_ff < BLEN_W'(nwords);
               if (blk_ff == blen - BLEN_W'(1)) begin
                  blk_in = '0;
                  if (!later && earlier) begin
                     st_load = 1'b1;
                     st_code = STS_TIME;
                  end else begin
                     if (later) begin
                        iopen_in = 1'b1;
                        itime_in = tword;
                        iend_in  = tword + samp_inc;
                     end else begin
                        iend_in  = iend_ff + samp_inc;
                     end
                     isnew_in = later;
                     if (nwords != '0) begin
                        state_in = ST_DRAIN;
                        nw_in    = nwords;
                        iss_in   = '0;
                        qv_in    = 1'b0;
                     end
                  end
               end else begin
                  blk_in = blk_ff + BLEN_W'(1);
               end
            end
         end

         // Status result closes the bank
         if (st_load) begin
            closed_in = 1'b1;
            ovalid_in = 1'b1;
            oword_in  = '0;
            onew_in   = 1'b0;
            otime_in  = st_zero_time ? '0 : itime_ff;
            okind_in  = KIND_STATUS;
            ocode_in  = st_code;
            olast_in  = 1'b1;
         end
      end

      // Drain: buffer read then output load
      if (drain_issue) begin
         iss_in    = iss_ff + NW_W'(1);
         qfirst_in = (iss_ff == '0);
         qlast_in  = (iss_ff == nw_ff - NW_W'(1));
      end
      if (drain_issue) begin
         qv_in = 1'b1;
      end else if (drain_load) begin
         qv_in = 1'b0;
      end
      if (drain_load) begin
         ovalid_in = 1'b1;
         oword_in  = buf_rd_data;
         onew_in   = qfirst_ff && isnew_ff;
         otime_in  = itime_ff;
         okind_in  = KIND_SAMPLES;
         ocode_in  = STS_OK;
         olast_in  = qlast_ff;
         if (qlast_ff) begin
            state_in = ST_IDLE;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         closed_ff <= 1'b1;
         pos_ff    <= '0;
         len_ff    <= '0;
         dbc_ff    <= '0;
         blk_ff    <= '0;
         itime_ff  <= '0;
         iend_ff   <= '0;
         iopen_ff  <= 1'b0;
         isnew_ff  <= 1'b0;
         nw_ff     <= '0;
         iss_ff    <= '0;
         qv_ff     <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         closed_ff <= closed_in;
         pos_ff    <= pos_in;
         len_ff    <= len_in;
         dbc_ff    <= dbc_in;
         blk_ff    <= blk_in;
         itime_ff  <= itime_in;
         iend_ff   <= iend_in;
         iopen_ff  <= iopen_in;
         isnew_ff  <= isnew_in;
         nw_ff     <= nw_in;
         iss_ff    <= iss_in;
         qv_ff     <= qv_in;
         ovalid_ff <= ovalid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      reqcnt_ff <= reqcnt_in;
      match_ff  <= match_in;
      qfirst_ff <= qfirst_in;
      qlast_ff  <= qlast_in;
      oword_ff  <= oword_in;
      onew_ff   <= onew_in;
      otime_ff  <= otime_in;
      okind_ff  <= okind_in;
      ocode_ff  <= ocode_in;
      olast_ff  <= olast_in;
   end

   // Block buffer
   wbip_buf_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_buf (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (blk_ff[ADDR_W-1:0]),
      .wr_data (req_data_word),
      .rd_en   (drain_issue),
      .rd_addr (iss_ff[ADDR_W-1:0]),
      .rd_data (buf_rd_data)
   );

   // Length remainder by block size
   wbip_rem_unit #(
      .BLEN_W (BLEN_W)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (req_bank_length - LEN_W'(4)),
      .divisor  (BLEN_W'({dbc_clamp, 1'b0}) + BLEN_W'(2)),
      .status   (rem_st)
   );

   // Outputs
   assign rsp_valid       = ovalid_ff;
   assign rsp_sample_0    = oword_ff[31:24];
   assign rsp_sample_1    = oword_ff[23:16];
   assign rsp_sample_2    = oword_ff[15:8];
   assign rsp_sample_3    = oword_ff[7:0];
   assign rsp_new_island  = onew_ff;
   assign rsp_island_time = $signed(otime_ff);
   assign rsp_result_kind = okind_ff;
   assign rsp_status_code = ocode_ff;
   assign rsp_last_of_run = olast_ff;

   // Checks
   `WBIP_ASSERT_IMPL(a_no_write_in_drain, (state_ff == ST_DRAIN), !buf_wr_en)
   `WBIP_ASSERT_IMPL(a_no_accept_in_rem, rem_st.busy, !req_acc)
   `WBIP_ASSERT_NEXT(a_drain_ends, (drain_load && qlast_ff), (state_ff == ST_IDLE))
   `WBIP_ASSERT_IMPL(a_issue_bounded, (state_ff == ST_DRAIN), (iss_ff <= nw_ff))

endmodule

### tb/sv/waveform_bank_island_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// waveform_bank_island_parser_tb
// Self-checking bench for the digitizer bank parser. Bank words are queued
// per phase and sent by a clocked driver. Each accepted word runs through
// a local parser model that queues the result words it should cause. The
// monitor checks every result word field by field against that queue. The
// phases sweep block size, personality and idle patterns.
// ----------------------------------------------------------------------------
module waveform_bank_island_parser_tb;
   import wbip_pkg::*;

   localparam int MAX_BLOCK_DBC  = 32;
   localparam int LATENCY_SETTLE = 40;      // length remainder plus drain margin
   localparam int CYCLE_LIMIT    = 400000;

   // defects injected into broken banks
   typedef enum int {
      FLAW_ZERO_REQ,
      FLAW_BIG_REQ,
      FLAW_RCV_DIFF,
      FLAW_STATUS,
      FLAW_LENGTH,
      FLAW_TRUNCATED
   } bank_flaw_type;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic              first;
      logic [LEN_W-1:0]  len;
   } bank_word_type;

   typedef struct packed {
      logic [7:0]        s0;
      logic [7:0]        s1;
      logic [7:0]        s2;
      logic [7:0]        s3;
      logic              new_isl;
      logic [DATA_W-1:0] itime;
      logic              kind;
      logic [CODE_W-1:0] code;
      logic              last;
   } result_word_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_wr_en = 1'b0;
   logic                     csr_index = 1'b0;
   logic [CSR_W-1:0]         csr_data = '0;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [DATA_W-1:0]        req_data_word = '0;
   logic                     req_first_word = 1'b0;
   logic [LEN_W-1:0]         req_bank_length = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [7:0]               rsp_sample_0;
   logic [7:0]               rsp_sample_1;
   logic [7:0]               rsp_sample_2;
   logic [7:0]               rsp_sample_3;
   logic                     rsp_new_island;
   logic signed [DATA_W-1:0] rsp_island_time;
   logic                     rsp_result_kind;
   logic [CODE_W-1:0]        rsp_status_code;
   logic                     rsp_last_of_run;

   waveform_bank_island_parser #(
      .MAX_DBC(MAX_BLOCK_DBC)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_word(req_data_word),
      .req_first_word(req_first_word),
      .req_bank_length(req_bank_length),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_sample_0(rsp_sample_0),
      .rsp_sample_1(rsp_sample_1),
      .rsp_sample_2(rsp_sample_2),
      .rsp_sample_3(rsp_sample_3),
      .rsp_new_island(rsp_new_island),
      .rsp_island_time(rsp_island_time),
      .rsp_result_kind(rsp_result_kind),
      .rsp_status_code(rsp_status_code),
      .rsp_last_of_run(rsp_last_of_run)
   );

   // stimulus and scoreboard
   bank_word_type   pending_words[$];
   result_word_type expected_rsp_words[$];
   result_word_type want;
   bank_word_type   next_word;
   int              words_queued = 0;
   int              mismatch_count = 0;
   int              cycle_count = 0;
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   bit              req_accepted = 1'b0;

   // parser model state
   logic [5:0]        cfg_dbc = 6'd1;
   logic [3:0]        cfg_pers = GOOD_PERSONALITY;
   logic [DATA_W-1:0] buf_words [0:2*MAX_BLOCK_DBC-1];
   int                bank_pos = 0;
   int                blk_fill = 0;
   int                bank_len = 0;
   int                bank_dbc = 0;
   logic [DATA_W-1:0] req_count = '0;
   logic [DATA_W-1:0] rcv_count = '0;
   logic [DATA_W-1:0] isl_time = '0;
   logic [DATA_W-1:0] isl_samples = '0;
   bit                isl_open = 1'b0;
   bit                bank_closed = 1'b1;

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- model
   function automatic void push_result(logic [DATA_W-1:0] w, logic isnew, logic kind,
                                       logic [CODE_W-1:0] code, logic last);
      result_word_type r;
      r = {w[31:24], w[23:16], w[15:8], w[7:0], isnew, isl_time, kind, code, last};
      expected_rsp_words.insert(expected_rsp_words.size(), r);
   endfunction

   function automatic void close_bank(logic [CODE_W-1:0] code);
      bank_closed = 1'b1;
      push_result('0, 1'b0, KIND_STATUS, code, 1'b1);
   endfunction

   // time word: decide the island, then drain the buffered samples
   function automatic void finish_block(logic [DATA_W-1:0] w);
      logic [DATA_W-1:0] t;
      logic [DATA_W-1:0] iend;
      bit                isnew;
      int                nw;
      int                i;
      t     = w & TIME_MASK;
      iend  = isl_time + isl_samples;
      nw    = 2 * bank_dbc;
      isnew = 1'b0;
      if (!isl_open || $signed(iend) < $signed(t)) begin
         isl_open    = 1'b1;
         isl_time    = t;
         isl_samples = '0;
         isnew       = 1'b1;
      end else if ($signed(t) < $signed(iend)) begin
         close_bank(STS_TIME);
         return;
      end
      for (i = 0; i < nw; i++)
         push_result(buf_words[i], isnew && i == 0, KIND_SAMPLES, STS_OK, i == nw - 1);
      isl_samples = isl_samples + 32'(8 * bank_dbc);
   endfunction

   function automatic void parse_bank_word(logic [DATA_W-1:0] w, logic first,
                                           logic [LEN_W-1:0] len);
      int pos;
      int blen;
      if (first) begin
         bank_pos    = 0;
         blk_fill    = 0;
         req_count   = '0;
         rcv_count   = '0;
         isl_time    = '0;
         isl_samples = '0;
         isl_open    = 1'b0;
         bank_closed = 1'b0;
         bank_len    = int'(len);
         bank_dbc    = (cfg_dbc > MAX_BLOCK_DBC) ? MAX_BLOCK_DBC : int'(cfg_dbc);
         if (cfg_pers != GOOD_PERSONALITY) begin
            close_bank(STS_PERSONALITY);
            return;
         end
         if (bank_len < 3) begin
            close_bank(STS_SHORT);
            return;
         end
      end
      if (bank_closed || bank_pos >= bank_len)
         return;
      pos      = bank_pos;
      bank_pos = bank_pos + 1;
      blen     = 2 * bank_dbc + 2;
      if (pos == 0) begin
         req_count = w;
      end else if (pos == 1) begin
         rcv_count = w;
      end else if (pos == 2) begin
         // header checks; a request with bit 31 set passes the size check
         if (req_count == 0)
            close_bank(STS_ZERO_REQ);
         else if (!req_count[31] && req_count >= BIG_REQUEST)
            close_bank(STS_BIG_REQ);
         else if (req_count != rcv_count || w != 0)
            close_bank(STS_MISMATCH);
         else if (bank_len < 4 || (bank_len - 4) % blen != 0)
            close_bank(STS_SIZE);
      end else if (pos == bank_len - 1) begin
         close_bank(STS_OK);
      end else begin
         if (blk_fill < 2 * MAX_BLOCK_DBC)
            buf_words[blk_fill] = w;
         if (blk_fill + 1 >= blen) begin
            blk_fill = 0;
            finish_block(w);
         end else begin
            blk_fill = blk_fill + 1;
         end
      end
   endfunction

   // ------------------------------------------------------------ generators
   function automatic void add_word(logic [DATA_W-1:0] d, logic f, logic [LEN_W-1:0] l);
      bank_word_type bw;
      bw = {d, f, l};
      pending_words.insert(pending_words.size(), bw);
      words_queued++;
   endfunction

   function automatic int active_dbc();
      return (cfg_dbc > MAX_BLOCK_DBC) ? MAX_BLOCK_DBC : int'(cfg_dbc);
   endfunction

   // well-formed bank; time words mostly continue or open islands
   function automatic void gen_good_bank();
      int                dbc;
      int                nblk;
      int                len;
      int                mode;
      int                b;
      int                i;
      logic [DATA_W-1:0] req;
      logic [DATA_W-1:0] t;
      logic [DATA_W-1:0] isl_start;
      logic [DATA_W-1:0] isl_len;
      bit                have_isl;
      dbc  = active_dbc();
      nblk = (dbc > 8) ? 1 : $urandom_range(1, 3);
      len  = 4 + nblk * (2 * dbc + 2);
      if ($urandom_range(0, 3) == 0)
         req = $urandom | 32'h8000_0000;
      else
         req = $urandom_range(1, int'(BIG_REQUEST) - 1);
      add_word(req, 1'b1, LEN_W'(len));
      add_word(req, 1'b0, LEN_W'(len));
      add_word('0, 1'b0, LEN_W'(len));
      have_isl  = 1'b0;
      isl_start = '0;
      isl_len   = '0;
      for (b = 0; b < nblk; b++) begin
         for (i = 0; i < 2 * dbc + 1; i++)
            add_word($urandom, 1'b0, LEN_W'(len));
         mode = $urandom_range(0, 99);
         if (have_isl && mode < 55)
            t = isl_start + isl_len;
         else if (have_isl && mode < 62)
            t = isl_start + isl_len - $urandom_range(1, 4096);
         else if (have_isl && mode < 85)
            t = isl_start + isl_len + $urandom_range(1, 4096);
         else
            t = $urandom;
         t = t & TIME_MASK;
         if (!have_isl || t != isl_start + isl_len) begin
            isl_start = t;
            isl_len   = '0;
         end
         have_isl = 1'b1;
         isl_len  = isl_len + 32'(8 * dbc);
         add_word(t | (32'($urandom_range(0, 1)) << 28), 1'b0, LEN_W'(len));
      end
      add_word($urandom, 1'b0, LEN_W'(len));
   endfunction

   // bank with one header or framing defect
   function automatic void gen_broken_bank();
      int                dbc;
      int                len;
      int                i;
      logic [DATA_W-1:0] req;
      logic [DATA_W-1:0] rcv;
      logic [DATA_W-1:0] sts;
      bank_flaw_type     flaw;
      dbc  = active_dbc();
      len  = 4 + (2 * dbc + 2) * $urandom_range(1, 2);
      req  = $urandom_range(1, 4096);
      rcv  = req;
      sts  = '0;
      flaw = bank_flaw_type'($urandom_range(0, 5));
      case (flaw)
         FLAW_ZERO_REQ: begin
            req = '0;
            rcv = $urandom_range(0, 1);
         end
         FLAW_BIG_REQ: begin
            req = $urandom_range(int'(BIG_REQUEST), 32'h7FFF_FFFF);
            rcv = req;
         end
         FLAW_RCV_DIFF: rcv = req ^ (32'd1 << $urandom_range(0, 31));
         FLAW_STATUS:   sts = $urandom | (32'd1 << $urandom_range(0, 31));
         FLAW_LENGTH: begin
            if ($urandom_range(0, 3) == 0)
               len = 3;
            else
               len = len + $urandom_range(1, 2 * dbc + 1);
         end
         default: ;
      endcase
      add_word(req, 1'b1, LEN_W'(len));
      add_word(rcv, 1'b0, LEN_W'(len));
      add_word(sts, 1'b0, LEN_W'(len));
      if (flaw == FLAW_TRUNCATED || flaw == FLAW_LENGTH) begin
         for (i = 0; i < $urandom_range(0, 2 * dbc + 1); i++)
            add_word($urandom, 1'b0, LEN_W'(len));
      end
   endfunction

   // stray words with random flags and lengths
   function automatic void gen_noise();
      int i;
      for (i = 0; i < $urandom_range(1, 4); i++)
         add_word($urandom, $urandom_range(0, 3) == 0,
                  LEN_W'($urandom_range(0, 21'h1F_FFFF)));
   endfunction

   task automatic run_random_banks(input int n_words);
      int goal;
      int pick;
      goal = words_queued + n_words;
      while (words_queued < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 72)
            gen_good_bank();
         else if (pick < 92)
            gen_broken_bank();
         else
            gen_noise();
      end
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      send_idle_pct  = sender_pct;
      recv_stall_pct = receiver_pct;
   endtask

   task automatic write_reg(input logic idx, input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == REG_BLOCKS_DBC)
         cfg_dbc = value;
      else
         cfg_pers = value[3:0];
   endtask

   task automatic write_personality(input logic [3:0] pers);
      write_reg(REG_PERSONALITY, {2'($urandom_range(0, 3)), pers});
   endtask

   // hold until every word is sent and every result word has come back
   task automatic wait_drained(input int settle);
      while (pending_words.size() > 0 || req_valid || expected_rsp_words.size() > 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // -------------------------------------------------------------- driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_word       = pending_words.pop_front();
            req_valid       <= 1'b1;
            req_data_word   <= next_word.data;
            req_first_word  <= next_word.first;
            req_bank_length <= next_word.len;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // ------------------------------------------------------------- monitor
   function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
         $error("%s: expected %0h, actual %0h", name, exp, act);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      req_accepted = !reset && req_valid && (req_stall === 1'b0);
      if (req_accepted)
         parse_bank_word(req_data_word, req_first_word, req_bank_length);
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_rsp_words.size() == 0) begin
            $error("result word with nothing expected");
            mismatch_count++;
         end else begin
            want = expected_rsp_words.pop_front();
            check_field("sample_0", 32'(want.s0), 32'(rsp_sample_0));
            check_field("sample_1", 32'(want.s1), 32'(rsp_sample_1));
            check_field("sample_2", 32'(want.s2), 32'(rsp_sample_2));
            check_field("sample_3", 32'(want.s3), 32'(rsp_sample_3));
            check_field("new_island", 32'(want.new_isl), 32'(rsp_new_island));
            check_field("island_time", want.itime, rsp_island_time);
            check_field("result_kind", 32'(want.kind), 32'(rsp_result_kind));
            check_field("status_code", 32'(want.code), 32'(rsp_status_code));
            check_field("last_of_run", 32'(want.last), 32'(rsp_last_of_run));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------- sequencing
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: header failures, short banks, one clean two-block island
      set_idling(0, 0);
      write_reg(REG_BLOCKS_DBC, 6'd1);
      write_personality(GOOD_PERSONALITY);
      add_word(32'hFFFF_FFFF, 1'b0, 21'h1F_FFFF);      // before any bank: ignored
      add_word(32'h0000_0000, 1'b1, 21'd0);            // length zero
      add_word(32'hFFFF_FFFF, 1'b1, 21'd2);            // length two
      add_word(32'h0000_0000, 1'b1, 21'd8);            // zero request
      add_word(32'h0000_0000, 1'b0, 21'd8);
      add_word(32'h0000_0000, 1'b0, 21'd8);
      add_word(BIG_REQUEST, 1'b1, 21'd8);              // request too large
      add_word(BIG_REQUEST, 1'b0, 21'd8);
      add_word(32'h0000_0000, 1'b0, 21'd8);
      add_word(32'h0000_0001, 1'b1, 21'd8);            // nonzero status word
      add_word(32'h0000_0001, 1'b0, 21'd8);
      add_word(32'h8000_0000, 1'b0, 21'd8);
      add_word(32'h0000_0001, 1'b1, 21'd3);            // length three: size fail
      add_word(32'h0000_0001, 1'b0, 21'd3);
      add_word(32'h0000_0000, 1'b0, 21'd3);
      add_word(32'h000F_FFFF, 1'b1, 21'd12);           // clean bank, two blocks
      add_word(32'h000F_FFFF, 1'b0, 21'd12);
      add_word(32'h0000_0000, 1'b0, 21'd12);
      add_word(32'hFFFF_FFFF, 1'b0, 21'd12);
      add_word(32'h0000_0000, 1'b0, 21'd12);
      add_word(32'h1234_5678, 1'b0, 21'd12);
      add_word(32'h9000_0000, 1'b0, 21'd12);           // bit 28 set, masked off
      add_word(32'hA5C3_0F96, 1'b0, 21'd12);
      add_word(32'h5A3C_F069, 1'b0, 21'd12);
      add_word(32'h0000_0000, 1'b0, 21'd12);
      add_word(32'h8000_0008, 1'b0, 21'd12);           // continues the island
      add_word(32'h0000_0000, 1'b0, 21'd12);           // spare word: ok status
      add_word(32'hDEAD_BEEF, 1'b0, 21'd12);           // after close: ignored
      wait_drained(LATENCY_SETTLE);

      run_random_banks(35);
      wait_drained(LATENCY_SETTLE);

      // sender idle, with one full pause mid-phase
      write_reg(REG_BLOCKS_DBC, 6'd2);
      set_idling(76, 0);
      run_random_banks(15);
      wait_drained(0);
      run_random_banks(15);
      wait_drained(LATENCY_SETTLE);

      // oversized block size, clamped to the largest blocks; receiver stalling
      write_reg(REG_BLOCKS_DBC, 6'd63);
      set_idling(0, 76);
      run_random_banks(30);
      wait_drained(LATENCY_SETTLE);

      // zero block size: islands without samples
      write_reg(REG_BLOCKS_DBC, 6'd0);
      set_idling(20, 20);
      run_random_banks(20);
      wait_drained(LATENCY_SETTLE);

      // rejected personalities on random banks
      write_personality(4'd15);
      run_random_banks(6);
      wait_drained(LATENCY_SETTLE);
      write_personality(4'd0);
      run_random_banks(6);
      wait_drained(LATENCY_SETTLE);

      write_personality(GOOD_PERSONALITY);
      write_reg(REG_BLOCKS_DBC, 6'd5);
      set_idling(76, 0);
      run_random_banks(20);
      wait_drained(LATENCY_SETTLE);

      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### files.f
+incdir+design
design/wbip_pkg.sv
design/wbip_buf_mem.sv
design/wbip_rem_unit.sv
design/waveform_bank_island_parser.sv
tb/sv/waveform_bank_island_parser_tb.sv
